[rtl/fan_tachometer_monitor_macros.svh]
// ----------------------------------------------------------------------------
// Fan tachometer monitor assertion macros
// Shared property shapes for the monitor's checkers.
// ----------------------------------------------------------------------------
`ifndef FAN_TACHOMETER_MONITOR_MACROS_SVH
`define FAN_TACHOMETER_MONITOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define FTM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fan_tachometer_monitor: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define FTM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fan_tachometer_monitor: next-cycle check failed");

`endif

[rtl/ftm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftm_pkg
// Types, widths and reset constants shared by the fan tachometer monitor.
// ----------------------------------------------------------------------------
package ftm_pkg;

  localparam int DIV_W       = 24;
  localparam int SPD_W       = 16;
  localparam int ERR_W       = 17;
  localparam int CNT_W       = 4;
  localparam int BLK_W       = 8;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 24;

  localparam int READINGS_DEF = 12;

  localparam logic [DIV_W-1:0] SCALE_RST  = 24'd1875000;
  localparam logic [SPD_W-1:0] MARGIN_RST = 16'd270;
  localparam logic [BLK_W-1:0] LIMIT_RST  = 8'd10;
  localparam logic [SPD_W-1:0] TARGET_RST = 16'd2700;

  typedef enum logic [1:0] {
    ACT_RISE = 2'd0,
    ACT_FALL = 2'd1,
    ACT_OVF  = 2'd2,
    ACT_REQ  = 2'd3
  } action_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SCALE  = 2'd0,
    REG_MARGIN = 2'd1,
    REG_LIMIT  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic apply;
  } cmd_t;

  typedef struct packed {
    logic is_fall;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

[rtl/ftm_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftm_div
// Restoring divider, one quotient bit per cycle, done pulse after the last.
// ----------------------------------------------------------------------------
module ftm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ftm_pkg::DIV_W-1:0] dividend,
  input  logic [ftm_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [ftm_pkg::DIV_W-1:0] quotient
);
  import ftm_pkg::*;

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  rem_r;
  logic [DIV_W-1:0]  quot_r;
  logic [DIV_W-1:0]  dvsr_r;
  logic [STEP_W-1:0] cnt_r;
  logic              done_r;
  logic [DIV_W:0]    trial;
  logic [DIV_W-1:0]  rem_nxt;
  logic [DIV_W-1:0]  quot_nxt;

  always_comb begin
    trial = {rem_r, quot_r[DIV_W-1]} - {1'b0, dvsr_r};
    if (trial[DIV_W]) begin
      rem_nxt = {rem_r[DIV_W-2:0], quot_r[DIV_W-1]};
    end else begin
      rem_nxt = trial[DIV_W-1:0];
    end
    quot_nxt = {quot_r[DIV_W-2:0], ~trial[DIV_W]};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quot_r <= dividend;
      dvsr_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= STEP_W'(DIV_W);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == STEP_W'(1));
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - STEP_W'(1);
      end
    end
  end

  assign done     = done_r;
  assign quotient = quot_r;

endmodule

[rtl/ftm_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftm_datapath
// Config registers, tachometer state, period and averaging math, result register.
// ----------------------------------------------------------------------------
module ftm_datapath #(
  parameter int READINGS_PER_AVERAGE = ftm_pkg::READINGS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ftm_pkg::cmd_t                   cmd,
  output ftm_pkg::stat_t                  stat,
  input  logic [ftm_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [ftm_pkg::IN_TUSER_W-1:0]  in_tuser,
  input  logic                            cfg_valid,
  input  logic [ftm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [ftm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic [ftm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ftm_pkg::*;

  localparam logic [CNT_W-1:0] RPA     = CNT_W'(READINGS_PER_AVERAGE);
  localparam logic [SPD_W-1:0] SPD_MAX = '1;
  localparam logic [BLK_W-1:0] BLK_MAX = '1;

  // average by reciprocal multiply, exact for every 16-bit sum
  localparam int AVG_D   = READINGS_PER_AVERAGE - 1;
  localparam int AVG_SH  = SPD_W + $clog2(AVG_D);
  localparam int AVG_M_W = SPD_W + 2;
  localparam int PROD_W  = SPD_W + AVG_SH;
  localparam logic [AVG_M_W-1:0] AVG_M = AVG_M_W'(((1 << AVG_SH) + AVG_D - 1) / AVG_D);

  // configuration
  logic [DIV_W-1:0] scale_r;
  logic [SPD_W-1:0] margin_r;
  logic [BLK_W-1:0] limit_r;

  // held item
  action_t          act_r;
  logic [SPD_W-1:0] cap_r;
  logic [SPD_W-1:0] req_r;

  // tachometer state
  logic [SPD_W-1:0] ovf_r,    ovf_nxt;
  logic [SPD_W-1:0] rise_r,   rise_nxt;
  logic [CNT_W-1:0] rc_r,     rc_nxt;
  logic [SPD_W-1:0] sum_r,    sum_nxt;
  logic [SPD_W-1:0] speed_r,  speed_nxt;
  logic [ERR_W-1:0] err_r,    err_nxt;
  logic             steady_r, steady_nxt;
  logic             pend_r,   pend_nxt;
  logic [BLK_W-1:0] blk_r,    blk_nxt;
  logic [SPD_W-1:0] target_r, target_nxt;
  logic             blocked_nxt;
  logic             ready_nxt;

  // result register
  logic             out_valid_r;
  logic             o_blocked_r;
  logic             o_ready_r;

  logic [2*SPD_W:0]  period;
  logic              per_bad;
  logic              per_big;
  logic [CNT_W-1:0]  rc_inc;
  logic              avg_due;
  logic [DIV_W-1:0]  quot;
  logic              div_done;
  logic [SPD_W-1:0]  rpm;
  logic [PROD_W-1:0] avg_prod;
  logic [SPD_W-1:0]  avg;
  logic [BLK_W-1:0]  blk_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= SCALE_RST;
      margin_r <= MARGIN_RST;
      limit_r  <= LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_SCALE:  scale_r  <= cfg_data;
        REG_MARGIN: margin_r <= cfg_data[SPD_W-1:0];
        REG_LIMIT:  limit_r  <= cfg_data[BLK_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action_t'(in_tuser);
      cap_r <= in_tdata[SPD_W-1:0];
      req_r <= in_tdata[2*SPD_W-1:SPD_W];
    end
  end

  // high time in ticks; negative or zero means no valid period
  always_comb begin
    period  = {1'b0, ovf_r, cap_r} - {{(SPD_W+1){1'b0}}, rise_r};
    per_bad = period[2*SPD_W] || (period == '0);
    per_big = |period[2*SPD_W-1:DIV_W];
    rc_inc  = rc_r + CNT_W'(1);
    avg_due = !(rc_inc < RPA);
  end

  ftm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (scale_r),
    .divisor  (period[DIV_W-1:0]),
    .done     (div_done),
    .quotient (quot)
  );

  always_comb begin
    if (per_bad) begin
      rpm = SPD_MAX;
    end else if (per_big) begin
      rpm = '0;
    end else if (|quot[DIV_W-1:SPD_W]) begin
      rpm = SPD_MAX;
    end else begin
      rpm = quot[SPD_W-1:0];
    end
    avg_prod = PROD_W'(sum_r) * PROD_W'(AVG_M);
    avg      = avg_prod[PROD_W-1:AVG_SH];
    blk_inc  = ((pend_r || steady_r) && (blk_r != BLK_MAX)) ? blk_r + BLK_W'(1) : blk_r;
  end

  always_comb begin
    ovf_nxt     = ovf_r;
    rise_nxt    = rise_r;
    rc_nxt      = rc_r;
    sum_nxt     = sum_r;
    speed_nxt   = speed_r;
    err_nxt     = err_r;
    steady_nxt  = steady_r;
    pend_nxt    = pend_r;
    blk_nxt     = blk_r;
    target_nxt  = target_r;
    blocked_nxt = 1'b0;
    ready_nxt   = 1'b0;
    case (act_r)
      ACT_RISE: begin
        ovf_nxt  = '0;
        rise_nxt = cap_r;
      end
      ACT_FALL: begin
        if (!avg_due) begin
          rc_nxt  = rc_inc;
          sum_nxt = sum_r + rpm;
        end else begin
          speed_nxt  = avg;
          err_nxt    = {1'b0, target_r} - {1'b0, avg};
          steady_nxt = ($signed(err_nxt) <= $signed({1'b0, margin_r}));
          rc_nxt     = '0;
          sum_nxt    = '0;
          ready_nxt  = 1'b1;
        end
        rise_nxt = '0;
      end
      ACT_OVF: begin
        if (ovf_r != SPD_MAX) begin
          ovf_nxt = ovf_r + SPD_W'(1);
        end
        blk_nxt = blk_inc;
        if (blk_inc > limit_r) begin
          blocked_nxt = 1'b1;
          blk_nxt     = '0;
          pend_nxt    = 1'b0;
        end
        if (ovf_nxt > SPD_W'(1)) begin
          speed_nxt = '0;
        end
      end
      ACT_REQ: begin
        target_nxt = req_r;
        pend_nxt   = 1'b1;
        steady_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r    <= '0;
      rise_r   <= '0;
      rc_r     <= '0;
      sum_r    <= '0;
      speed_r  <= '0;
      err_r    <= '0;
      steady_r <= 1'b0;
      pend_r   <= 1'b0;
      blk_r    <= '0;
      target_r <= TARGET_RST;
    end else if (cmd.apply) begin
      ovf_r    <= ovf_nxt;
      rise_r   <= rise_nxt;
      rc_r     <= rc_nxt;
      sum_r    <= sum_nxt;
      speed_r  <= speed_nxt;
      err_r    <= err_nxt;
      steady_r <= steady_nxt;
      pend_r   <= pend_nxt;
      blk_r    <= blk_nxt;
      target_r <= target_nxt;
    end
  end

  // flags of the result; the other fields read straight from the state
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      o_blocked_r <= blocked_nxt;
      o_ready_r   <= ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.apply) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.is_fall  = (act_r == ACT_FALL);
  assign stat.div_done = div_done;
  assign stat.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, o_ready_r, o_blocked_r, pend_r, steady_r, err_r, speed_r};

endmodule

[rtl/ftm_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftm_ctrl
// Sequencer: take an item, run the divider for falling captures, post the result.
// ----------------------------------------------------------------------------
module ftm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  ftm_pkg::stat_t stat,
  output ftm_pkg::cmd_t  cmd
);
  import ftm_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_START;
      ST_START: state_nxt = stat.is_fall ? ST_DIV : ST_APPLY;
      ST_DIV:   if (stat.div_done) state_nxt = ST_APPLY;
      ST_APPLY: if (stat.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd.load      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.apply     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_START: cmd.div_start = stat.is_fall;
      ST_DIV:   ;
      ST_APPLY: cmd.apply = stat.out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/fan_tachometer_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_tachometer_monitor
// Fan speed from capture events: rpm readings, averaging, stall and blocked timeout.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  in_      slave      tvalid / tready     tdata: capture, request; tuser: action
//  out_     master     tvalid / tready     tdata: speed, error, flags
//  cfg_     slave      valid / ready       addr: register index, data: value
//
//  A rising capture, overflow tick or speed request runs idle, start, apply.
//  A falling capture also waits in the divide state on the 24-step divider
//  that forms the rpm reading; the average comes from a reciprocal multiply.
//  Reset (rst_n low, synchronous) restores config, tachometer and control state.
//  A result waiting on out_tready holds the item in its last step.
// ----------------------------------------------------------------------------
module fan_tachometer_monitor #(
  parameter int READINGS_PER_AVERAGE = ftm_pkg::READINGS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [15:0] capture_value, [31:16] requested_speed
  input  logic [ftm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] action
  input  logic [ftm_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [15:0] current_speed, [32:16] speed_error, [33] steady, [34] request_pending,
  // [35] blocked_check, [36] average_ready, [39:37] zero
  output logic [ftm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ftm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [ftm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ftm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  ftm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ftm_datapath #(
    .READINGS_PER_AVERAGE (READINGS_PER_AVERAGE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid && cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

[rtl/fan_tachometer_monitor_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_tachometer_monitor_chk
// Port-level checks on the monitor, bound to the top level.
// ----------------------------------------------------------------------------
`include "fan_tachometer_monitor_macros.svh"

module fan_tachometer_monitor_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [ftm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ftm_pkg::*;

  // one item at a time: no second accept right after the first
  `FTM_ASSERT_NXT(a_one_item, in_tvalid && in_tready, !in_tready)

  // a stalled result holds
  `FTM_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // an average and a blocked timeout come from different actions
  `FTM_ASSERT_IMP(a_flags_apart, out_tvalid, !(out_tdata[36] && out_tdata[35]))

  // the blocked timeout drops the pending request
  `FTM_ASSERT_IMP(a_blocked_clears, out_tvalid && out_tdata[35], !out_tdata[34])

endmodule

bind fan_tachometer_monitor fan_tachometer_monitor_chk u_chk (.*);
